// ===== hdl/rgbhsl_pkg.sv =====
package rgbhsl_pkg;

   typedef struct packed {
      logic valid;
      logic gray;
      logic sat_zero;
   } rgbhsl_ctl_type;

endpackage

// ===== hdl/rgb_to_hsl_converter.sv =====
// Converts one RGB pixel to hue, saturation and lightness in a fully pipelined datapath that
// takes a new item in every clock cycle unless the result side stalls. Lightness is max+min
// exactly; hue and saturation are truncated fractions of FRACTION_BITS bits, with saturation
// reaching exactly one as 2^FRACTION_BITS. One stage finds max, min, sector and divisors, and
// then FRACTION_BITS+1 restoring division stages follow. Each of them produces one quotient
// bit of the saturation divider, and every one after the first also produces one quotient bit
// of the hue divider beside it. A stall on the result side holds every occupied stage, and
// empty stages still fill from the input.
module rgb_to_hsl_converter
   import rgbhsl_pkg::*;
#(
   parameter int COLOR_BITS = 8,
   parameter int FRACTION_BITS = 12,
   localparam int ReqWidth = ((3 * COLOR_BITS + 7) / 8) * 8,
   localparam int RspWidth = ((2 * FRACTION_BITS + COLOR_BITS + 2 + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqWidth-1:0] req_tdata,  // red, green, blue
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspWidth-1:0] rsp_tdata   // hue, saturation, lightness
);

   localparam int Stages = FRACTION_BITS + 2;
   localparam logic [COLOR_BITS-1:0] Full = '1;
   localparam logic [COLOR_BITS:0] FullTwice = {Full, 1'b0};
   localparam logic [FRACTION_BITS:0] SatOne = {1'b1, {FRACTION_BITS{1'b0}}};

   logic [COLOR_BITS-1:0]    red, green, blue;
   logic [COLOR_BITS-1:0]    mx, mn, range_w, den_w;
   logic [COLOR_BITS:0]      light_w, den_wide;
   logic [COLOR_BITS+2:0]    six_w, num_w;
   rgbhsl_ctl_type           front_ctl;

   rgbhsl_ctl_type           ctl_s     [Stages];
   logic                     rdy_s     [Stages+1];
   logic [COLOR_BITS+2:0]    hue_rem_s [Stages];
   logic [FRACTION_BITS-1:0] hue_quo_s [Stages];
   logic [COLOR_BITS+2:0]    six_s     [Stages];
   logic [COLOR_BITS-1:0]    sat_rem_s [Stages];
   logic [FRACTION_BITS:0]   sat_quo_s [Stages];
   logic [COLOR_BITS-1:0]    den_s     [Stages];
   logic [COLOR_BITS:0]      light_s   [Stages];

   rgbhsl_ctl_type           ctl0_ff;
   logic [COLOR_BITS+2:0]    num_ff;
   logic [COLOR_BITS+2:0]    six_ff;
   logic [COLOR_BITS-1:0]    range_ff;
   logic [COLOR_BITS-1:0]    den_ff;
   logic [COLOR_BITS:0]      light_ff;

   logic [FRACTION_BITS-1:0] rsp_hue;
   logic [FRACTION_BITS:0]   rsp_sat;
   logic [COLOR_BITS:0]      rsp_light;

   assign red   = req_tdata[COLOR_BITS-1:0];
   assign green = req_tdata[2*COLOR_BITS-1:COLOR_BITS];
   assign blue  = req_tdata[3*COLOR_BITS-1:2*COLOR_BITS];

   always_comb begin
      mx = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      mn = red;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      range_w = mx - mn;
      light_w = {1'b0, mx} + {1'b0, mn};
      six_w   = {1'b0, range_w, 2'b00} + {2'b00, range_w, 1'b0};

      priority if (blue == mx) begin
         num_w = {1'b0, range_w, 2'b00} + {3'b000, red} - {3'b000, green};
      end else if (green == mx) begin
         num_w = {2'b00, range_w, 1'b0} + {3'b000, blue} - {3'b000, red};
      end else if (green >= blue) begin
         num_w = {3'b000, green - blue};
      end else begin
         num_w = six_w - {3'b000, blue - green};
      end

      den_wide = FullTwice - light_w;
      if (light_w <= {1'b0, Full}) begin
         den_w = light_w[COLOR_BITS-1:0];
      end else begin
         den_w = den_wide[COLOR_BITS-1:0];
      end

      front_ctl.valid    = req_tvalid;
      front_ctl.gray     = (range_w == '0);
      front_ctl.sat_zero = (light_w == '0) || (light_w == FullTwice);
   end

   assign req_tready = !ctl0_ff.valid || rdy_s[1];
   assign rdy_s[0]   = req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl0_ff <= '0;
      end else if (req_tready) begin
         ctl0_ff <= front_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         num_ff   <= num_w;
         six_ff   <= six_w;
         range_ff <= range_w;
         den_ff   <= den_w;
         light_ff <= light_w;
      end
   end

   assign ctl_s[0]     = ctl0_ff;
   assign hue_rem_s[0] = num_ff;
   assign hue_quo_s[0] = '0;
   assign six_s[0]     = six_ff;
   assign sat_rem_s[0] = range_ff;
   assign sat_quo_s[0] = '0;
   assign den_s[0]     = den_ff;
   assign light_s[0]   = light_ff;

   for (genvar k = 1; k < Stages; k++) begin : g_step
      rgbhsl_div_stage #(
         .COLOR_BITS    (COLOR_BITS),
         .FRACTION_BITS (FRACTION_BITS),
         .FIRST_STEP    (k == 1)
      ) u_step (
         .clock       (clock),
         .reset       (reset),
         .in_ctl      (ctl_s[k-1]),
         .in_ready    (rdy_s[k]),
         .in_hue_rem  (hue_rem_s[k-1]),
         .in_hue_quo  (hue_quo_s[k-1]),
         .in_six      (six_s[k-1]),
         .in_sat_rem  (sat_rem_s[k-1]),
         .in_sat_quo  (sat_quo_s[k-1]),
         .in_den      (den_s[k-1]),
         .in_light    (light_s[k-1]),
         .out_ctl     (ctl_s[k]),
         .out_ready   (rdy_s[k+1]),
         .out_hue_rem (hue_rem_s[k]),
         .out_hue_quo (hue_quo_s[k]),
         .out_six     (six_s[k]),
         .out_sat_rem (sat_rem_s[k]),
         .out_sat_quo (sat_quo_s[k]),
         .out_den     (den_s[k]),
         .out_light   (light_s[k])
      );
   end

   assign rdy_s[Stages] = rsp_tready;

   assign rsp_tvalid = ctl_s[Stages-1].valid;
   assign rsp_hue    = ctl_s[Stages-1].gray ? '0 : hue_quo_s[Stages-1];
   assign rsp_sat    = ctl_s[Stages-1].sat_zero ? '0 : sat_quo_s[Stages-1];
   assign rsp_light  = light_s[Stages-1];
   assign rsp_tdata  = RspWidth'({rsp_light, rsp_sat, rsp_hue});

   a_empty_takes_input: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("Input stalled while the result stage is empty.");

   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_sat <= SatOne)
      else $error("Saturation exceeds one.");

   a_extreme_light: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_light == '0 || rsp_light == FullTwice) |-> rsp_sat == '0)
      else $error("Black or white item has nonzero saturation.");

   a_gray_hue: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_sat == '0 |-> rsp_hue == '0)
      else $error("Gray item has nonzero hue.");

endmodule

// ===== hdl/rgbhsl_div_stage.sv =====
module rgbhsl_div_stage
   import rgbhsl_pkg::*;
#(
   parameter int COLOR_BITS = 8,
   parameter int FRACTION_BITS = 12,
   parameter bit FIRST_STEP = 1'b0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  rgbhsl_ctl_type               in_ctl,
   output logic                         in_ready,
   input  logic [COLOR_BITS+2:0]        in_hue_rem,
   input  logic [FRACTION_BITS-1:0]     in_hue_quo,
   input  logic [COLOR_BITS+2:0]        in_six,
   input  logic [COLOR_BITS-1:0]        in_sat_rem,
   input  logic [FRACTION_BITS:0]       in_sat_quo,
   input  logic [COLOR_BITS-1:0]        in_den,
   input  logic [COLOR_BITS:0]          in_light,
   output rgbhsl_ctl_type               out_ctl,
   input  logic                         out_ready,
   output logic [COLOR_BITS+2:0]        out_hue_rem,
   output logic [FRACTION_BITS-1:0]     out_hue_quo,
   output logic [COLOR_BITS+2:0]        out_six,
   output logic [COLOR_BITS-1:0]        out_sat_rem,
   output logic [FRACTION_BITS:0]       out_sat_quo,
   output logic [COLOR_BITS-1:0]        out_den,
   output logic [COLOR_BITS:0]          out_light
);

   rgbhsl_ctl_type               ctl_ff;
   logic [COLOR_BITS+2:0]        hue_rem_ff, hue_rem_in;
   logic [FRACTION_BITS-1:0]     hue_quo_ff, hue_quo_in;
   logic [COLOR_BITS+2:0]        six_ff;
   logic [COLOR_BITS-1:0]        sat_rem_ff, sat_rem_in;
   logic [FRACTION_BITS:0]       sat_quo_ff, sat_quo_in;
   logic [COLOR_BITS-1:0]        den_ff;
   logic [COLOR_BITS:0]          light_ff;

   logic [COLOR_BITS+3:0]        hue_dbl;
   logic [COLOR_BITS+3:0]        hue_diff;
   logic                         hue_ge;
   logic [COLOR_BITS:0]          sat_cand;
   logic [COLOR_BITS:0]          sat_diff;
   logic                         sat_ge;

   assign in_ready = !ctl_ff.valid || out_ready;

   always_comb begin
      hue_dbl  = {in_hue_rem, 1'b0};
      hue_diff = hue_dbl - {1'b0, in_six};
      hue_ge   = hue_dbl >= {1'b0, in_six};
      if (FIRST_STEP) begin
         hue_rem_in = in_hue_rem;
         hue_quo_in = in_hue_quo;
      end else begin
         hue_rem_in = hue_ge ? hue_diff[COLOR_BITS+2:0] : hue_dbl[COLOR_BITS+2:0];
         hue_quo_in = {in_hue_quo[FRACTION_BITS-2:0], hue_ge};
      end

      if (FIRST_STEP) begin
         sat_cand = {1'b0, in_sat_rem};
      end else begin
         sat_cand = {in_sat_rem, 1'b0};
      end
      sat_diff   = sat_cand - {1'b0, in_den};
      sat_ge     = sat_cand >= {1'b0, in_den};
      sat_rem_in = sat_ge ? sat_diff[COLOR_BITS-1:0] : sat_cand[COLOR_BITS-1:0];
      sat_quo_in = {in_sat_quo[FRACTION_BITS-1:0], sat_ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (in_ready) begin
         ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_ctl.valid) begin
         hue_rem_ff <= hue_rem_in;
         hue_quo_ff <= hue_quo_in;
         six_ff     <= in_six;
         sat_rem_ff <= sat_rem_in;
         sat_quo_ff <= sat_quo_in;
         den_ff     <= in_den;
         light_ff   <= in_light;
      end
   end

   assign out_ctl     = ctl_ff;
   assign out_hue_rem = hue_rem_ff;
   assign out_hue_quo = hue_quo_ff;
   assign out_six     = six_ff;
   assign out_sat_rem = sat_rem_ff;
   assign out_sat_quo = sat_quo_ff;
   assign out_den     = den_ff;
   assign out_light   = light_ff;

endmodule

// ===== dv/rgb_to_hsl_converter_checker.sv =====
`timescale 1ns / 100ps

module rgb_to_hsl_converter_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // red, green, blue
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // hue, saturation, lightness
   output int          fail_count,
   output int          results_pending
);

   typedef struct packed {
      logic [11:0] hue;
      logic [12:0] saturation;
      logic [8:0]  lightness;
   } hsl_pixel_type;

   hsl_pixel_type expected_hsl[$];

   function automatic hsl_pixel_type convert_pixel(input int red, input int green,
                                                   input int blue);
      int brightest;
      int darkest;
      int span;
      int sum;
      int sixths;
      int numer;
      int offset;
      int den;
      int frac;
      hsl_pixel_type pixel;
      brightest = red;
      darkest = red;
      if (green > brightest) brightest = green;
      if (blue > brightest) brightest = blue;
      if (green < darkest) darkest = green;
      if (blue < darkest) darkest = blue;
      span = brightest - darkest;
      sum = brightest + darkest;
      pixel = '0;
      if (span != 0) begin
         sixths = 6 * span;
         // Blue wins a tie for the largest component, then green, then red.
         if (blue == brightest) begin
            numer = 4 * span + red - green;
         end else if (green == brightest) begin
            numer = 2 * span + blue - red;
         end else if (green >= blue) begin
            numer = green - blue;
         end else begin
            numer = sixths - (blue - green);
         end
         frac = (numer << 12) / sixths;
         if (frac > 4095) frac = 4095;
         pixel.hue = frac[11:0];
      end
      if (sum != 0 && sum != 510) begin
         offset = (sum > 255) ? sum - 255 : 255 - sum;
         den = 255 - offset;
         if (den != 0) begin
            frac = (span << 12) / den;
            if (frac > 4096) frac = 4096;
            pixel.saturation = frac[12:0];
         end
      end
      pixel.lightness = sum[8:0];
      return pixel;
   endfunction

   function automatic void compare_field(input string field, input int want, input int got);
      if (want != got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      hsl_pixel_type want;
      if (reset) begin
         expected_hsl.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            expected_hsl.push_back(convert_pixel(int'(req_tdata[7:0]), int'(req_tdata[15:8]),
                                                 int'(req_tdata[23:16])));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_hsl.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected item, expected none, actual 0x%h", $time, rsp_tdata);
            end else begin
               want = expected_hsl.pop_front();
               compare_field("hue", int'(want.hue), int'(rsp_tdata[11:0]));
               compare_field("saturation", int'(want.saturation), int'(rsp_tdata[24:12]));
               compare_field("lightness", int'(want.lightness), int'(rsp_tdata[33:25]));
            end
         end
      end
      results_pending = expected_hsl.size();
   end

endmodule

// ===== dv/rgb_to_hsl_converter_test.sv =====
`timescale 1ns / 100ps

module rgb_to_hsl_converter_test;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // red, green, blue
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // hue, saturation, lightness
   int          fail_count;
   int          results_pending;
   int          idle_pct = 21;
   logic        hold_request = 1'b0;
   int          hold_left = 0;

   always begin
      #2;
      clock = 1'b1;
      #2;
      clock = 1'b0;
   end

   rgb_to_hsl_converter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   rgb_to_hsl_converter_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .fail_count      (fail_count),
      .results_pending (results_pending)
   );

   task automatic offer_pixel(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {blue, green, red};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic offer_random_pixels(input int count);
      logic [7:0] comp[3];
      logic [7:0] hi;
      logic [7:0] lo;
      int odd;
      repeat (count) begin
         case ($urandom_range(9))
            0: begin
               hi = 8'($urandom_range(255));
               comp = '{hi, hi, hi};
            end
            1: begin
               hi = 8'($urandom_range(255));
               lo = 8'($urandom_range(int'(hi)));
               odd = $urandom_range(2);
               foreach (comp[k]) comp[k] = (k == odd) ? lo : hi;
            end
            2, 3: begin
               foreach (comp[k]) begin
                  case ($urandom_range(2))
                     0: comp[k] = 8'd0;
                     1: comp[k] = 8'd255;
                     default: comp[k] = 8'($urandom_range(255));
                  endcase
               end
            end
            default: begin
               foreach (comp[k]) comp[k] = 8'($urandom_range(255));
            end
         endcase
         offer_pixel(comp[0], comp[1], comp[2]);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
   endtask

   initial begin
      #400000;
      $display("[rgb_to_hsl_converter] ERROR");
      $finish;
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 400;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      offer_pixel(8'd0, 8'd0, 8'd0);
      offer_pixel(8'd255, 8'd255, 8'd255);
      offer_pixel(8'd128, 8'd128, 8'd128);
      offer_pixel(8'd1, 8'd1, 8'd1);
      offer_pixel(8'd254, 8'd254, 8'd254);
      offer_pixel(8'd255, 8'd0, 8'd0);
      offer_pixel(8'd0, 8'd255, 8'd0);
      offer_pixel(8'd0, 8'd0, 8'd255);
      offer_pixel(8'd255, 8'd255, 8'd0);
      offer_pixel(8'd255, 8'd0, 8'd255);
      offer_pixel(8'd0, 8'd255, 8'd255);
      offer_pixel(8'd255, 8'd0, 8'd10);
      offer_pixel(8'd255, 8'd0, 8'd1);
      offer_pixel(8'd255, 8'd10, 8'd0);
      offer_pixel(8'd1, 8'd0, 8'd0);
      offer_pixel(8'd255, 8'd254, 8'd254);
      offer_pixel(8'd200, 8'd100, 8'd50);
      offer_pixel(8'd50, 8'd200, 8'd100);
      offer_pixel(8'd100, 8'd50, 8'd200);
      offer_pixel(8'd170, 8'd85, 8'd85);
      wait_drained();

      offer_random_pixels(500);
      hold_request = 1'b1;
      offer_random_pixels(400);
      idle_pct = 0;
      offer_random_pixels(400);
      idle_pct = 21;
      wait_drained();
      offer_random_pixels(500);

      wait_drained();
      repeat (30) @(negedge clock);
      if (fail_count == 0 && results_pending == 0) begin
         $display("[rgb_to_hsl_converter] OK");
      end else begin
         $display("[rgb_to_hsl_converter] ERROR");
      end
      $finish;
   end

endmodule
